@@ hw/rtl/blpm_pkg.sv @@
// Types, constants and arithmetic helpers of the bone local pose block.
// No dependencies; imported by blpm_qmul, blpm_rotmat and the top level.
`timescale 1ns / 1ps
`default_nettype none
package blpm_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned OutW  = 32;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  typedef struct packed {
    logic [47:0] anim_offset;
    logic [47:0] base_offset;
    logic [47:0] append_offset;
    logic [63:0] anim_quat;
    logic [63:0] base_quat;
    logic [63:0] ik_quat;
    logic [63:0] append_quat;
    logic [47:0] axis_scale;
    logic        use_ik;
    logic        use_append_offset;
    logic        use_append_rotation;
  } pose_t;

  typedef struct packed {
    logic signed [OutW-1:0] m00;
    logic signed [OutW-1:0] m01;
    logic signed [OutW-1:0] m02;
    logic signed [OutW-1:0] m03;
    logic signed [OutW-1:0] m10;
    logic signed [OutW-1:0] m11;
    logic signed [OutW-1:0] m12;
    logic signed [OutW-1:0] m13;
    logic signed [OutW-1:0] m20;
    logic signed [OutW-1:0] m21;
    logic signed [OutW-1:0] m22;
    logic signed [OutW-1:0] m23;
  } matrix_t;

  // Rounds a Q4.28 sum to Q2.14 with half rounding up, then saturates.
  function automatic comp_t round_sat(input logic signed [34:0] acc);
    logic signed [34:0] r;
    r = (acc + 35'sd8192) >>> 14;
    if (r > 35'sd32767) begin
      return 16'sh7fff;
    end else if (r < -35'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/blpm_if.sv @@
// Valid/ready channel carrying one item of the given payload type.
// Depends on nothing; payload types come from blpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface blpm_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/blpm_qmul.sv @@
// Registered Hamilton product of two quaternions with Q2.14 rounding.
// Depends on blpm_pkg. One stage: products and sums, result registered.
`timescale 1ns / 1ps
`default_nettype none
module blpm_qmul
  import blpm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire quat_t p_i,
  input  wire quat_t q_i,
  output quat_t      r_o
);
  logic signed [34:0] w_d, x_d, y_d, z_d;
  quat_t r_q;

  function automatic logic signed [34:0] m(input comp_t a, input comp_t b);
    return 35'(a * b);
  endfunction

  always_comb begin
    w_d = m(p_i.w, q_i.w) - m(p_i.x, q_i.x) - m(p_i.y, q_i.y) - m(p_i.z, q_i.z);
    x_d = m(p_i.w, q_i.x) + m(p_i.x, q_i.w) + m(p_i.y, q_i.z) - m(p_i.z, q_i.y);
    y_d = m(p_i.w, q_i.y) + m(p_i.y, q_i.w) + m(p_i.z, q_i.x) - m(p_i.x, q_i.z);
    z_d = m(p_i.w, q_i.z) + m(p_i.z, q_i.w) + m(p_i.x, q_i.y) - m(p_i.y, q_i.x);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= '{w: round_sat(w_d), x: round_sat(x_d), y: round_sat(y_d), z: round_sat(z_d)};
    end
  end

  assign r_o = r_q;
endmodule
`default_nettype wire

@@ hw/rtl/blpm_rotmat.sv @@
// Rotation matrix terms in Q.28 and their scaling to Q16.16, two stages.
// Depends on blpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module blpm_rotmat
  import blpm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [1:0]  en_i,
  input  wire quat_t       q_i,
  input  wire logic [47:0] scale_i,
  output logic signed [OutW-1:0] m_o [9]
);
  logic signed [31:0] sq_d [9];
  logic signed [31:0] sq_q [9];
  logic signed [33:0] rt [9];
  logic [47:0] s_q;
  logic signed [OutW-1:0] m_q [9];
  comp_t sc [3];

  always_comb begin
    // Products: xx yy zz xy xz yz wx wy wz.
    sq_d[0] = q_i.x * q_i.x;
    sq_d[1] = q_i.y * q_i.y;
    sq_d[2] = q_i.z * q_i.z;
    sq_d[3] = q_i.x * q_i.y;
    sq_d[4] = q_i.x * q_i.z;
    sq_d[5] = q_i.y * q_i.z;
    sq_d[6] = q_i.w * q_i.x;
    sq_d[7] = q_i.w * q_i.y;
    sq_d[8] = q_i.w * q_i.z;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q <= sq_d;
      s_q  <= scale_i;
    end
  end

  always_comb begin
    sc[0] = s_q[47:32];
    sc[1] = s_q[31:16];
    sc[2] = s_q[15:0];
    rt[0] = 34'sh10000000 - 34'(2 * (35'(sq_q[1]) + 35'(sq_q[2])));
    rt[1] = 34'(2 * (35'(sq_q[3]) - 35'(sq_q[8])));
    rt[2] = 34'(2 * (35'(sq_q[4]) + 35'(sq_q[7])));
    rt[3] = 34'(2 * (35'(sq_q[3]) + 35'(sq_q[8])));
    rt[4] = 34'sh10000000 - 34'(2 * (35'(sq_q[0]) + 35'(sq_q[2])));
    rt[5] = 34'(2 * (35'(sq_q[5]) - 35'(sq_q[6])));
    rt[6] = 34'(2 * (35'(sq_q[4]) - 35'(sq_q[7])));
    rt[7] = 34'(2 * (35'(sq_q[5]) + 35'(sq_q[6])));
    rt[8] = 34'sh10000000 - 34'(2 * (35'(sq_q[0]) + 35'(sq_q[1])));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= OutW'((50'(rt[i]) * 50'(sc[i % 3]) + 50'sd8388608) >>> 24);
      end
    end
  end

  assign m_o = m_q;
endmodule
`default_nettype wire

@@ hw/rtl/bone_local_pose_to_matrix_core.sv @@
// Top level of the bone local pose to matrix block.
// Depends on blpm_pkg, blpm_if, blpm_qmul and blpm_rotmat.
//
// Usage: pose_in carries one bone's pose terms per item, matrix_out one
// 3x4 Q16.16 local transform per item. Both are valid/ready channels.
// The pipeline has six register stages: three quaternion products (the IK
// and inherited products pass the quaternion through when disabled), the
// rotation term products, the scaled matrix terms and the output register.
// Each result is offered once its item has passed through every stage, and
// one item is accepted every cycle while the receiver takes results.
// When the receiver stalls, the full stages nearest the output hold; stages
// behind an empty stage still move, so input is taken while any is empty.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module bone_local_pose_to_matrix_core
  import blpm_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  blpm_if.sink     pose_in,
  blpm_if.source   matrix_out
);
  localparam int unsigned Stages = 6;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] en;
  pose_t p0_q, p1_q;
  logic [47:0] s_q;
  logic signed [OutW-1:0] t_q [Stages-1][3];
  quat_t q0, q1, q2, ik_sel, q1_in, ap_sel, q2_in;
  logic signed [OutW-1:0] mr [9];

  // Stage k may load when it is empty or its content moves on.
  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || matrix_out.ready;
    for (int k = Stages-2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pose_in.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = Stages-1; k >= 1; k--) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
      if (en[0]) vld_q[0] <= pose_in.valid;
    end
  end

  function automatic logic signed [OutW-1:0] tsum(input pose_t p, input int unsigned sh);
    logic signed [17:0] a;
    a = 18'(signed'(p.anim_offset[sh+:16])) + 18'(signed'(p.base_offset[sh+:16]));
    if (p.use_append_offset) a = a + 18'(signed'(p.append_offset[sh+:16]));
    return OutW'(a) <<< 10;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p0_q <= pose_in.data;
      t_q[0][0] <= tsum(pose_in.data, 32);
      t_q[0][1] <= tsum(pose_in.data, 16);
      t_q[0][2] <= tsum(pose_in.data, 0);
    end
    if (en[1]) begin
      p1_q <= p0_q;
      t_q[1] <= t_q[0];
    end
    for (int k = 2; k < Stages-1; k++) begin
      if (en[k]) t_q[k] <= t_q[k-1];
    end
    if (en[2]) begin
      s_q <= p1_q.axis_scale;
    end
  end

  blpm_qmul u_base (.clk_i, .en_i(en[0]), .p_i(quat_t'(pose_in.data.anim_quat)),
                    .q_i(quat_t'(pose_in.data.base_quat)), .r_o(q0));

  always_comb begin
    ik_sel = p0_q.use_ik ? quat_t'(p0_q.ik_quat) : '{w: 16'sh4000, x: '0, y: '0, z: '0};
    q1_in  = q0;
  end

  blpm_qmul u_ik (.clk_i, .en_i(en[1]), .p_i(ik_sel), .q_i(q1_in), .r_o(q1));

  always_comb begin
    ap_sel = p1_q.use_append_rotation ? quat_t'(p1_q.append_quat)
                                      : '{w: 16'sh4000, x: '0, y: '0, z: '0};
    q2_in  = q1;
  end

  blpm_qmul u_app (.clk_i, .en_i(en[2]), .p_i(q2_in), .q_i(ap_sel), .r_o(q2));

  blpm_rotmat u_rot (.clk_i, .en_i({en[4], en[3]}), .q_i(q2), .scale_i(s_q), .m_o(mr));

  assign matrix_out.valid = vld_q[Stages-1];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      matrix_out.data <= '{m00: mr[0], m01: mr[1], m02: mr[2], m03: t_q[4][0],
                           m10: mr[3], m11: mr[4], m12: mr[5], m13: t_q[4][1],
                           m20: mr[6], m21: mr[7], m22: mr[8], m23: t_q[4][2]};
    end
  end
endmodule
`default_nettype wire
